// File: rtl/rcc_pkg.sv
// Shared constants and word functions for the record cipher codec.
package rcc_pkg;

    localparam int unsigned RECORD_WORDS_DEF = 42;
    localparam int unsigned CHECK_PASSES_DEF = 8;

    localparam logic [31:0] CK_SEED   = 32'hB7E1_5163;
    localparam logic [31:0] Q_STEP    = 32'h61C8_8647;
    localparam logic [31:0] KEY_DELTA = 32'h481E_AE9D;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    function automatic logic [31:0] bswap(input logic [31:0] x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // swapped domain: xor key, invert, subtract Q
    function automatic logic [31:0] enc_word(input logic [31:0] w, input logic [31:0] key);
        enc_word = bswap(~(bswap(w) ^ key) - Q_STEP);
    endfunction

    // swapped domain: add Q, invert, xor key
    function automatic logic [31:0] dec_word(input logic [31:0] w, input logic [31:0] key);
        dec_word = bswap(~(bswap(w) + Q_STEP) ^ key);
    endfunction

endpackage

// File: rtl/rcc_cksum.sv
// Word store and checksum sweep: one xor-subtract step per cycle over the stored record.
module rcc_cksum #(
    parameter int unsigned RECORD_WORDS = rcc_pkg::RECORD_WORDS_DEF,
    parameter int unsigned CHECK_PASSES = rcc_pkg::CHECK_PASSES_DEF,
    parameter int unsigned IDX_W        = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [31:0]      i_wr_data,
    input  logic             i_start,
    output logic             o_done,
    output logic [31:0]      o_acc
);
    import rcc_pkg::*;

    localparam int unsigned PASS_W = (CHECK_PASSES > 1) ? $clog2(CHECK_PASSES) : 1;

    logic [31:0]       r_mem [RECORD_WORDS];
    logic [31:0]       r_rd_data;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [PASS_W-1:0] r_pass;
    logic              r_issue;
    logic              r_rd_vld;
    logic              r_rd_last;
    logic              r_done;
    logic [31:0]       r_acc;
    logic              last_idx;
    logic              last_addr;

    assign last_idx  = (r_rd_idx == IDX_W'(RECORD_WORDS - 1));
    assign last_addr = last_idx && (r_pass == PASS_W'(CHECK_PASSES - 1));

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
            r_rd_idx  <= '0;
            r_pass    <= '0;
            r_acc     <= CK_SEED;
        end else begin
            r_done    <= 1'b0;
            r_rd_vld  <= r_issue;
            r_rd_last <= r_issue && last_addr;
            if (i_start) begin
                r_issue  <= 1'b1;
                r_rd_idx <= '0;
                r_pass   <= '0;
                r_acc    <= CK_SEED;
            end else if (r_issue) begin
                if (last_idx) begin
                    r_rd_idx <= '0;
                    if (last_addr) begin
                        r_issue <= 1'b0;
                    end else begin
                        r_pass <= r_pass + PASS_W'(1);
                    end
                end else begin
                    r_rd_idx <= r_rd_idx + IDX_W'(1);
                end
            end
            // read data comes back in the cycle after its address is issued
            if (r_rd_vld) begin
                r_acc <= (bswap(r_rd_data) ^ r_acc) - Q_STEP;
                if (r_rd_last) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

// File: rtl/record_cipher_codec_core.sv
// Record cipher codec top level: word cipher, sequencer and output register.
//
// Each accepted dword yields its transformed word in the cycle after it is accepted, and the
// next dword can be taken in the following cycle as long as the output register is being
// drained. In encode mode the final word of a record is followed by a checksum sweep over the
// stored record through the word store's single read port, one step per cycle, so that word
// holds the input off through the sweep before the checksum word and the seed word are sent;
// the seed word carries last. In decode mode last marks the final word of the record. The
// direction register may only be written with the block idle.
module record_cipher_codec_core #(
    parameter int unsigned RECORD_WORDS = rcc_pkg::RECORD_WORDS_DEF,
    parameter int unsigned CHECK_PASSES = rcc_pkg::CHECK_PASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [31:0] i_key_seed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_out_word,
    output logic        o_last
);
    import rcc_pkg::*;

    localparam int unsigned IDX_W = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;

    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_CHECK    = 4'b0010,
        S_TR_CK    = 4'b0100,
        S_TR_SEED  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic             r_dir;
    logic [IDX_W-1:0] r_idx;
    logic [31:0]      r_key;
    logic [31:0]      r_seed;
    logic             r_out_valid;
    logic [31:0]      r_out_word;
    logic             r_out_last;

    logic             slot_free;
    logic             accept;
    logic             first_word;
    logic             final_word;
    logic [31:0]      cur_key;
    logic [31:0]      cipher_word;
    logic             ck_start;
    logic             ck_done;
    logic [31:0]      ck_acc;
    logic             load_out;
    logic [31:0]      load_word;
    logic             load_last;

    assign slot_free  = !r_out_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE) && slot_free;
    assign accept     = i_valid && o_ready;
    assign first_word = (r_idx == '0);
    assign final_word = (r_idx == IDX_W'(RECORD_WORDS - 1));
    assign cur_key    = first_word ? i_key_seed : r_key;
    assign cipher_word = (r_dir == DIR_DECODE) ? dec_word(i_data_word, cur_key)
                                               : enc_word(i_data_word, cur_key);
    assign ck_start   = accept && final_word && (r_dir == DIR_ENCODE);

    rcc_cksum #(
        .RECORD_WORDS (RECORD_WORDS),
        .CHECK_PASSES (CHECK_PASSES),
        .IDX_W        (IDX_W)
    ) u_cksum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (accept),
        .i_wr_addr (r_idx),
        .i_wr_data (i_data_word),
        .i_start   (ck_start),
        .o_done    (ck_done),
        .o_acc     (ck_acc)
    );

    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        load_word = cipher_word;
        load_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    load_out  = 1'b1;
                    load_last = final_word && (r_dir == DIR_DECODE);
                    if (ck_start) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (ck_done) begin
                    n_state = S_TR_CK;
                end
            end
            S_TR_CK: begin
                // running key has already stepped to the trailer index
                if (slot_free) begin
                    load_out  = 1'b1;
                    load_word = bswap(~(ck_acc ^ r_key) - Q_STEP);
                    n_state   = S_TR_SEED;
                end
            end
            S_TR_SEED: begin
                if (slot_free) begin
                    load_out  = 1'b1;
                    load_word = bswap(r_seed);
                    load_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dir       <= DIR_ENCODE;
            r_idx       <= '0;
            r_key       <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_dir <= i_cfg_data;
            end
            if (accept) begin
                r_idx <= final_word ? '0 : r_idx + IDX_W'(1);
                r_key <= cur_key - KEY_DELTA;
                if (first_word) begin
                    r_seed <= i_key_seed;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_word <= load_word;
            r_out_last <= load_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out_word;
    assign o_last     = r_out_last;

endmodule

// File: rtl/rcc_checker.sv
// Port-level checks for the record cipher codec, bound to the top level.
module rcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_ready,
    input logic        o_valid,
    input logic [31:0] o_out_word,
    input logic        o_last
);

    // a stalled result keeps its word and last flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_word) && $stable(o_last))
        else $error("result changed while stalled");

    // no new transaction taken while the output register is full and stalled
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result stalled");

    // every accepted word shows a result in the next cycle
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted word produced no result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind record_cipher_codec_core rcc_checker u_rcc_checker (.*);
